@@ src/sle_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sle_pkg;

    // Width of the saturating decoded-length counter.
    localparam int LENGTH_BITS = 16;

    // Most results that one input byte can cause.
    localparam int MAX_RESULTS = 5;
    localparam int CNT_W = $clog2(MAX_RESULTS + 1);

    // Depths of the command queue and of the result queue.
    localparam int CQ_DEPTH = 2;
    localparam int OQ_DEPTH = 2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BTICK  = 8'h60;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_X  = 8'h78;
    localparam logic [7:0] CH_LOW_U  = 8'h75;
    localparam logic [7:0] CH_SEMI   = 8'h3B;

    // Bytes that the simple escapes stand for.
    localparam logic [7:0] VAL_NUL = 8'h00;
    localparam logic [7:0] VAL_TAB = 8'h09;
    localparam logic [7:0] VAL_LF  = 8'h0A;
    localparam logic [7:0] VAL_CR  = 8'h0D;

    // Error codes of the status result.
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_QUOTES   = 3'd1;
    localparam logic [2:0] ERR_DANGLING = 3'd2;
    localparam logic [2:0] ERR_ESCAPE   = 3'd3;
    localparam logic [2:0] ERR_HEX      = 3'd4;
    localparam logic [2:0] ERR_UNICODE  = 3'd5;

    // Most hex digits in a \u escape.
    localparam logic [2:0] MAX_UNI_DIGITS = 3'd6;

    // Decoder phase.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BODY,
        PH_ESC,
        PH_HEX1,
        PH_HEX2,
        PH_UNI
    } phase_t;

    // One input byte with its literal marks.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       first_byte;
        logic       last_byte;
    } in_item_t;

    // One result.
    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   is_status;
        logic [2:0]             error_code;
        logic [LENGTH_BITS-1:0] decoded_length;
        logic                   run_last;
    } out_item_t;

    // All the results that one input byte causes, as the front part hands them on.
    typedef struct packed {
        logic [CNT_W-1:0]                n_data;
        logic [MAX_RESULTS-1:0][7:0]     data;
        logic                            has_status;
        logic [2:0]                      err;
        logic [LENGTH_BITS-1:0]          len;
    } cmd_t;

endpackage

`default_nettype wire

@@ src/string_literal_unescaper.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake           Payload
// input     push / full         item   (in_byte, first_byte, last_byte)
// result    pop / empty         result (data_byte, is_status, error_code,
//                                       decoded_length, run_last)
//
// The front decoder takes one byte per cycle while the command queue has room.
// The back part delivers one result per cycle while the result queue has room, so a byte
// with N results holds the back part until all N are delivered (up to five for a \u value and its terminator).
// A result reaches the result ports only after passing through the command queue and then the result queue.
// Reset puts the decoder in idle, waiting for a byte marked first_byte, and empties both queues.
// A stalled result side fills the result queue, then the command queue, then raises full.

module string_literal_unescaper (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire sle_pkg::in_item_t   item,
    input  wire logic                pop,
    output logic                     empty,
    output sle_pkg::out_item_t       result
);
    import sle_pkg::*;

    cmd_t cmd_in;
    cmd_t cmd_head;
    logic cmd_push;
    logic cq_full;
    logic cq_empty;
    logic cmd_pop;
    logic accept;

    assign full   = cq_full;
    assign accept = push && !cq_full;

    // Front: decoder state machine.
    sle_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cmd      (cmd_in),
        .cmd_push (cmd_push)
    );

    // Queue between front and back.
    sle_cmd_queue u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .cmd_in  (cmd_in),
        .full    (cq_full),
        .pop     (cmd_pop),
        .cmd_out (cmd_head),
        .empty   (cq_empty)
    );

    // Back: expands commands into results.
    sle_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .cmd_valid (!cq_empty),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ src/sle_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sle_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire sle_pkg::in_item_t item,
    output sle_pkg::cmd_t          cmd,
    output logic                   cmd_push
);
    import sle_pkg::*;

    localparam logic [LENGTH_BITS:0] LEN_MAX = {1'b0, {LENGTH_BITS{1'b1}}};

    phase_t                 phase_reg, phase_next;
    logic [7:0]             quote_reg, quote_next;
    logic [3:0]             hi_reg, hi_next;
    logic [23:0]            cp_reg, cp_next;
    logic [2:0]             dc_reg, dc_next;
    logic [2:0]             err_reg, err_next;
    logic [LENGTH_BITS-1:0] bc_reg, bc_next;

    logic [7:0]             c;
    logic                   is_hex;
    logic [3:0]             hex_val;
    logic                   is_quote;
    logic                   utf_ok;
    logic [2:0]             utf_cnt;
    logic [3:0][7:0]        utf_bytes;
    logic [LENGTH_BITS:0]   bc_wide;
    logic [LENGTH_BITS-1:0] bc_sat;

    assign c = item.in_byte;
    assign is_quote = (c == CH_DQUOTE) || (c == CH_SQUOTE) || (c == CH_BTICK);

    // Hex digit decode.
    always_comb
    begin
        is_hex  = 1'b1;
        hex_val = 4'd0;
        case (c) inside
            [8'h30:8'h39]: hex_val = c[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: hex_val = c[3:0] + 4'd9;
            default:       is_hex = 1'b0;
        endcase
    end

    // UTF-8 encoding of the pending code point.
    always_comb
    begin
        utf_ok    = 1'b1;
        utf_cnt   = 3'd0;
        utf_bytes = '0;
        if (cp_reg < 24'h80)
        begin
            utf_cnt      = 3'd1;
            utf_bytes[0] = cp_reg[7:0];
        end
        else if (cp_reg < 24'h800)
        begin
            utf_cnt      = 3'd2;
            utf_bytes[0] = {3'b110, cp_reg[10:6]};
            utf_bytes[1] = {2'b10, cp_reg[5:0]};
        end
        else if (cp_reg < 24'h10000)
        begin
            utf_cnt      = 3'd3;
            utf_bytes[0] = {4'b1110, cp_reg[15:12]};
            utf_bytes[1] = {2'b10, cp_reg[11:6]};
            utf_bytes[2] = {2'b10, cp_reg[5:0]};
        end
        else if (cp_reg <= 24'h10FFFF)
        begin
            utf_cnt      = 3'd4;
            utf_bytes[0] = {5'b11110, cp_reg[20:18]};
            utf_bytes[1] = {2'b10, cp_reg[17:12]};
            utf_bytes[2] = {2'b10, cp_reg[11:6]};
            utf_bytes[3] = {2'b10, cp_reg[5:0]};
        end
        else
        begin
            utf_ok = 1'b0;
        end
    end

    // Next state of the decoder.
    always_comb
    begin
        phase_next = phase_reg;
        quote_next = quote_reg;
        hi_next    = hi_reg;
        cp_next    = cp_reg;
        dc_next    = dc_reg;
        err_next   = err_reg;
        bc_next    = bc_reg;
        if (accept)
        begin
            if (item.first_byte)
            begin
                quote_next = c;
                bc_next    = '0;
                hi_next    = 4'd0;
                cp_next    = 24'd0;
                dc_next    = 3'd0;
                err_next   = is_quote ? ERR_NONE : ERR_QUOTES;
                phase_next = item.last_byte ? PH_IDLE : PH_BODY;
            end
            else if (phase_reg == PH_IDLE)
            begin
                phase_next = PH_IDLE;
            end
            else if (item.last_byte)
            begin
                phase_next = PH_IDLE;
                bc_next    = bc_sat;
            end
            else if (err_reg == ERR_NONE)
            begin
                bc_next = bc_sat;
                case (phase_reg)
                    PH_BODY:
                    begin
                        if (c == CH_BSLASH)
                            phase_next = PH_ESC;
                    end
                    PH_ESC:
                    begin
                        phase_next = PH_BODY;
                        case (c)
                            CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_BTICK,
                            CH_ZERO, CH_LOW_T, CH_LOW_N, CH_LOW_R: ;
                            CH_LOW_X: phase_next = PH_HEX1;
                            CH_LOW_U:
                            begin
                                phase_next = PH_UNI;
                                cp_next    = 24'd0;
                                dc_next    = 3'd0;
                            end
                            default: err_next = ERR_ESCAPE;
                        endcase
                    end
                    PH_HEX1:
                    begin
                        if (is_hex)
                        begin
                            hi_next    = hex_val;
                            phase_next = PH_HEX2;
                        end
                        else
                            err_next = ERR_HEX;
                    end
                    PH_HEX2:
                    begin
                        if (is_hex)
                            phase_next = PH_BODY;
                        else
                            err_next = ERR_HEX;
                    end
                    PH_UNI:
                    begin
                        if (is_hex)
                        begin
                            if (dc_reg >= MAX_UNI_DIGITS)
                                err_next = ERR_UNICODE;
                            else
                            begin
                                cp_next = {cp_reg[19:0], hex_val};
                                dc_next = dc_reg + 3'd1;
                            end
                        end
                        else if (dc_reg == 3'd0 || !utf_ok)
                            err_next = ERR_UNICODE;
                        else if (c == CH_BSLASH)
                            phase_next = PH_ESC;
                        else
                            phase_next = PH_BODY;
                    end
                    default: phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // Results caused by the byte, as one command.
    always_comb
    begin
        cmd            = '0;
        if (accept)
        begin
            if (item.first_byte)
            begin
                if (item.last_byte)
                begin
                    cmd.has_status = 1'b1;
                    cmd.err        = ERR_QUOTES;
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
                cmd.has_status = 1'b0;
            end
            else if (item.last_byte)
            begin
                cmd.has_status = 1'b1;
                if (c != quote_reg)
                    cmd.err = ERR_QUOTES;
                else if (err_reg != ERR_NONE)
                    cmd.err = err_reg;
                else if (phase_reg == PH_ESC)
                    cmd.err = ERR_DANGLING;
                else if (phase_reg == PH_HEX1 || phase_reg == PH_HEX2)
                    cmd.err = ERR_HEX;
                else if (phase_reg == PH_UNI)
                begin
                    if (dc_reg == 3'd0 || !utf_ok)
                        cmd.err = ERR_UNICODE;
                    else
                    begin
                        cmd.n_data    = CNT_W'(utf_cnt);
                        cmd.data[3:0] = utf_bytes;
                    end
                end
            end
            else if (err_reg == ERR_NONE)
            begin
                case (phase_reg)
                    PH_BODY:
                    begin
                        if (c != CH_BSLASH)
                        begin
                            cmd.n_data  = CNT_W'(1);
                            cmd.data[0] = c;
                        end
                    end
                    PH_ESC:
                    begin
                        cmd.n_data = CNT_W'(1);
                        case (c)
                            CH_BSLASH, CH_DQUOTE, CH_SQUOTE, CH_BTICK: cmd.data[0] = c;
                            CH_ZERO:  cmd.data[0] = VAL_NUL;
                            CH_LOW_T: cmd.data[0] = VAL_TAB;
                            CH_LOW_N: cmd.data[0] = VAL_LF;
                            CH_LOW_R: cmd.data[0] = VAL_CR;
                            default:  cmd.n_data  = '0;
                        endcase
                    end
                    PH_HEX2:
                    begin
                        if (is_hex)
                        begin
                            cmd.n_data  = CNT_W'(1);
                            cmd.data[0] = {hi_reg, hex_val};
                        end
                    end
                    PH_UNI:
                    begin
                        if (!is_hex && dc_reg != 3'd0 && utf_ok)
                        begin
                            cmd.data[3:0] = utf_bytes;
                            cmd.n_data    = CNT_W'(utf_cnt);
                            // Any terminator but ';' or a backslash is a body byte.
                            if (c != CH_SEMI && c != CH_BSLASH)
                            begin
                                cmd.data[utf_cnt] = c;
                                cmd.n_data        = CNT_W'(utf_cnt) + CNT_W'(1);
                            end
                        end
                    end
                    default: cmd.n_data = '0;
                endcase
            end
        end
        // Length after this byte's data results, saturating.
        bc_wide  = {1'b0, bc_reg} + (LENGTH_BITS+1)'(cmd.n_data);
        bc_sat   = (bc_wide > LEN_MAX) ? LEN_MAX[LENGTH_BITS-1:0]
                                       : bc_wide[LENGTH_BITS-1:0];
        // A literal closed on its opening byte has decoded nothing.
        cmd.len  = (cmd.has_status && !item.first_byte) ? bc_sat : '0;
        cmd_push = accept && (cmd.has_status || cmd.n_data != '0);
    end

    // Decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            quote_reg <= 8'd0;
            hi_reg    <= 4'd0;
            cp_reg    <= 24'd0;
            dc_reg    <= 3'd0;
            err_reg   <= ERR_NONE;
            bc_reg    <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            quote_reg <= quote_next;
            hi_reg    <= hi_next;
            cp_reg    <= cp_next;
            dc_reg    <= dc_next;
            err_reg   <= err_next;
            bc_reg    <= bc_next;
        end
    end

endmodule

`default_nettype wire

@@ src/sle_cmd_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sle_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire sle_pkg::cmd_t cmd_in,
    output logic               full,
    input  wire logic          pop,
    output sle_pkg::cmd_t      cmd_out,
    output logic               empty
);
    import sle_pkg::*;

    localparam int PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
    localparam int CNT_QW = $clog2(CQ_DEPTH + 1);

    cmd_t              slot_reg [CQ_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_QW-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == CNT_QW'(CQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign cmd_out = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and fill count update.
    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (do_push)
            wr_next = (wr_reg == PTR_W'(CQ_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        if (do_pop)
            rd_next = (rd_reg == PTR_W'(CQ_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_QW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_QW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_reg] <= cmd_in;
    end

endmodule

`default_nettype wire

@@ src/sle_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sle_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire sle_pkg::cmd_t  cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_pop,
    input  wire logic           pop,
    output logic                empty,
    output sle_pkg::out_item_t  result
);
    import sle_pkg::*;

    localparam int PTR_W = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
    localparam int CNT_QW = $clog2(OQ_DEPTH + 1);

    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  total;
    out_item_t         cur;
    logic              oq_full;
    logic              oq_push, oq_pop;
    out_item_t         slot_reg [OQ_DEPTH];
    logic [PTR_W-1:0]  wr_reg, wr_next;
    logic [PTR_W-1:0]  rd_reg, rd_next;
    logic [CNT_QW-1:0] count_reg, count_next;

    // Result taken from the head command at the current index.
    assign total = cmd.n_data + CNT_W'(cmd.has_status);
    always_comb
    begin
        cur          = '0;
        cur.run_last = (idx_reg == total - CNT_W'(1));
        if (idx_reg < cmd.n_data)
            cur.data_byte = cmd.data[idx_reg];
        else
        begin
            cur.is_status      = 1'b1;
            cur.error_code     = cmd.err;
            cur.decoded_length = cmd.len;
        end
    end

    assign oq_push = cmd_valid && !oq_full;
    assign cmd_pop = oq_push && cur.run_last;
    assign idx_next = !oq_push ? idx_reg : (cur.run_last ? '0 : idx_reg + CNT_W'(1));

    // Result queue: parts the expander from the consumer.
    assign oq_full = (count_reg == CNT_QW'(OQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign result  = slot_reg[rd_reg];
    assign oq_pop  = pop && !empty;

    always_comb
    begin
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (oq_push)
            wr_next = (wr_reg == PTR_W'(OQ_DEPTH - 1)) ? '0 : wr_reg + PTR_W'(1);
        if (oq_pop)
            rd_next = (rd_reg == PTR_W'(OQ_DEPTH - 1)) ? '0 : rd_reg + PTR_W'(1);
        if (oq_push && !oq_pop)
            count_next = count_reg + CNT_QW'(1);
        else if (oq_pop && !oq_push)
            count_next = count_reg - CNT_QW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Result storage.
    always_ff @(posedge clk)
    begin
        if (oq_push)
            slot_reg[wr_reg] <= cur;
    end

endmodule

`default_nettype wire
